@@ design/rgcf_pkg.sv @@
// ----------------------------------------------------------------------------
// rgcf_pkg
// Shared constants, register indexes and types of the radial gradient fill.
// ----------------------------------------------------------------------------
package rgcf_pkg;

   // Parameter defaults
   localparam int COORD_BITS_DEF    = 16;
   localparam int POS_FRAC_BITS_DEF = 16;

   // Fixed field widths
   localparam int FIELD_W  = 16;
   localparam int RADIUS_W = 12;
   localparam int COLOR_W  = 32;
   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Distance arithmetic: squared distance of an inside pixel fits D2_W bits,
   // the radicand is that value in Q.16, the root is the distance in Q.8
   localparam int D2_W   = 2 * RADIUS_W;
   localparam int RAD_W  = D2_W + 16;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COLOR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_END_COLOR   = 3'd4;

   // Data that travels alongside the distance through the long units
   typedef struct packed {
      logic [FIELD_W-1:0] x;
      logic [FIELD_W-1:0] y;
      logic               hit;
      logic               nonzero;
   } side_type;

endpackage

@@ design/rgcf_if.sv @@
// ----------------------------------------------------------------------------
// rgcf_if
// Valid/ready channels of the radial gradient fill: request, response, CSR.
// ----------------------------------------------------------------------------
interface rgcf_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [rgcf_pkg::FIELD_W-1:0] pixel_x;
   logic signed [rgcf_pkg::FIELD_W-1:0] pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rgcf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rgcf_pkg::FIELD_W-1:0] out_x;
   logic signed [rgcf_pkg::FIELD_W-1:0] out_y;
   logic                                inside_res;
   logic [rgcf_pkg::CHAN_W-1:0]         red;
   logic [rgcf_pkg::CHAN_W-1:0]         green;
   logic [rgcf_pkg::CHAN_W-1:0]         blue;
   logic [rgcf_pkg::CHAN_W-1:0]         alpha;
   modport source (output valid, output out_x, output out_y, output inside_res,
                   output red, output green, output blue, output alpha, input ready);
   modport sink   (input valid, input out_x, input out_y, input inside_res,
                   input red, input green, input blue, input alpha, output ready);
endinterface

interface rgcf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rgcf_pkg::CSR_IDX_W-1:0]      index;
   logic [rgcf_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/rgcf_sqrt.sv @@
// ----------------------------------------------------------------------------
// rgcf_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rgcf_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [rgcf_pkg::RAD_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [rgcf_pkg::ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0]           out_side
);
   import rgcf_pkg::*;

   logic              valid_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff   [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic              prev_valid;
      logic [RAD_W-1:0]  prev_rad;
      logic [REM_W-1:0]  prev_rem;
      logic [ROOT_W-1:0] prev_root;
      logic [SIDE_W-1:0] prev_side;
      logic [REM_W+1:0]  cat;
      logic [REM_W+1:0]  trial;
      logic              fits;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RAD_W-1:0]  rad_in;

      if (i == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rad   = in_rad;
         assign prev_rem   = '0;
         assign prev_root  = '0;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[i-1];
         assign prev_rad   = rad_ff[i-1];
         assign prev_rem   = rem_ff[i-1];
         assign prev_root  = root_ff[i-1];
         assign prev_side  = side_ff[i-1];
      end

      // Bring down the next bit pair and try the next root bit
      always_comb begin
         cat     = {prev_rem, prev_rad[RAD_W-1 -: 2]};
         trial   = (REM_W+2)'({prev_root, 2'b01});
         fits    = (cat >= trial);
         rem_in  = fits ? REM_W'(cat - trial) : REM_W'(cat);
         root_in = {prev_root[ROOT_W-2:0], fits};
         rad_in  = {prev_rad[RAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[i]  <= rad_in;
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

@@ design/rgcf_div.sv @@
// ----------------------------------------------------------------------------
// rgcf_div
// Pipelined restoring divider for the position, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgcf_div #(
   parameter int SIDE_W             = 1,
   parameter int POSITION_FRAC_BITS = rgcf_pkg::POS_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [rgcf_pkg::ROOT_W-1:0] divisor,
   input  logic                        in_valid,
   input  logic [rgcf_pkg::ROOT_W-1:0] in_dist,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [POSITION_FRAC_BITS:0] out_quot,
   output logic [SIDE_W-1:0]           out_side
);
   import rgcf_pkg::*;

   localparam int NSTAGE = POSITION_FRAC_BITS + 1;

   logic              valid_ff [NSTAGE];
   logic [ROOT_W-1:0] rem_ff   [NSTAGE];
   logic [NSTAGE-1:0] quot_ff  [NSTAGE];
   logic [SIDE_W-1:0] side_ff  [NSTAGE];

   for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
      logic              prev_valid;
      logic [ROOT_W-1:0] prev_rem;
      logic [NSTAGE-1:0] prev_quot;
      logic [SIDE_W-1:0] prev_side;
      logic [ROOT_W:0]   cat;
      logic              fits;
      logic [ROOT_W-1:0] rem_in;

      // First stage yields the integer bit, the rest one fraction bit each
      if (i == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = in_dist;
         assign prev_quot  = '0;
         assign prev_side  = in_side;
         assign cat        = {1'b0, prev_rem};
      end else begin : g_next
         assign prev_valid = valid_ff[i-1];
         assign prev_rem   = rem_ff[i-1];
         assign prev_quot  = quot_ff[i-1];
         assign prev_side  = side_ff[i-1];
         assign cat        = {prev_rem, 1'b0};
      end

      always_comb begin
         fits   = (cat >= {1'b0, divisor});
         rem_in = fits ? ROOT_W'(cat - {1'b0, divisor}) : ROOT_W'(cat);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i]  <= rem_in;
            quot_ff[i] <= {prev_quot[NSTAGE-2:0], fits};
            side_ff[i] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign out_quot  = quot_ff[NSTAGE-1];
   assign out_side  = side_ff[NSTAGE-1];

endmodule

@@ design/radial_gradient_circle_fill.sv @@
// ----------------------------------------------------------------------------
// radial_gradient_circle_fill
// Per-pixel radial gradient shader with an inside-circle test.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while the output is not stalled and returns one
// result per pixel, in order. The pipeline holds three stages for offset,
// squares and the radius test, 20 stages of square root (one root bit each),
// POSITION_FRAC_BITS + 1 stages of division (one quotient bit each), then
// a product stage and the output register. The whole pipeline stalls while
// a result waits on rsp, so req.ready follows rsp.ready through that one
// output register. Configuration writes are taken at once and must only be
// made with no request in flight.
module radial_gradient_circle_fill #(
   parameter int COORD_BITS         = rgcf_pkg::COORD_BITS_DEF,
   parameter int POSITION_FRAC_BITS = rgcf_pkg::POS_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   rgcf_req_if.sink   req,
   rgcf_rsp_if.source rsp,
   rgcf_csr_if.sink   csr
);
   import rgcf_pkg::*;

   localparam int P        = POSITION_FRAC_BITS;
   localparam int POS_W    = P + 1;
   localparam int PROD_W   = P + 11;
   localparam int CRD_W    = FIELD_W + 1;
   localparam int SIGN_IDX = (COORD_BITS <= FIELD_W) ? COORD_BITS - 1 : FIELD_W - 1;
   localparam int SIDE_W   = $bits(side_type);

   // Sign-extend a coordinate from COORD_BITS
   function automatic logic signed [CRD_W-1:0] sext_coord(input logic [FIELD_W-1:0] v);
      logic [CRD_W-1:0] r;
      r = '0;
      for (int i = 0; i < CRD_W; i++) begin
         if (i < COORD_BITS && i < FIELD_W) begin
            r[i] = v[i];
         end else if (COORD_BITS <= FIELD_W) begin
            r[i] = v[SIGN_IDX];
         end
      end
      return signed'(r);
   endfunction

   // Keep only the low COORD_BITS of a passed-through coordinate
   function automatic logic [FIELD_W-1:0] mask_coord(input logic [FIELD_W-1:0] v);
      logic [FIELD_W-1:0] r;
      r = '0;
      for (int i = 0; i < FIELD_W; i++) begin
         if (i < COORD_BITS) begin
            r[i] = v[i];
         end
      end
      return r;
   endfunction

   // Configuration registers
   logic [FIELD_W-1:0]  center_x_ff, center_y_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic [COLOR_W-1:0]  start_color_ff, end_color_ff;
   logic [D2_W-1:0]     r2_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         radius_ff      <= '0;
         start_color_ff <= '0;
         end_color_ff   <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_CENTER_X:    center_x_ff    <= csr.data[FIELD_W-1:0];
            CSR_CENTER_Y:    center_y_ff    <= csr.data[FIELD_W-1:0];
            CSR_RADIUS:      radius_ff      <= csr.data[RADIUS_W-1:0];
            CSR_START_COLOR: start_color_ff <= csr.data[COLOR_W-1:0];
            CSR_END_COLOR:   end_color_ff   <= csr.data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Radius squared, settled long before any request reaches the test
   always_ff @(posedge clock) begin
      r2_ff <= radius_ff * radius_ff;
   end

   // Pipeline advances whenever the output register is free or being taken
   logic rsp_valid_ff;
   logic advance;
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   // Stage 1: offsets from the centre and their magnitudes
   logic                    s1_valid_ff, s1_far_ff;
   logic [RADIUS_W-1:0]     s1_ax_ff, s1_ay_ff;
   logic [FIELD_W-1:0]      s1_x_ff, s1_y_ff;
   logic signed [CRD_W:0]   dx, dy;
   logic [CRD_W:0]          ax_full, ay_full;
   logic                    far_in;

   always_comb begin
      dx = (CRD_W+1)'(sext_coord(req.pixel_x)) - (CRD_W+1)'(sext_coord(center_x_ff));
      dy = (CRD_W+1)'(sext_coord(req.pixel_y)) - (CRD_W+1)'(sext_coord(center_y_ff));
      ax_full = dx[CRD_W] ? unsigned'(-dx) : unsigned'(dx);
      ay_full = dy[CRD_W] ? unsigned'(-dy) : unsigned'(dy);
      far_in  = (ax_full[CRD_W:RADIUS_W] != '0) || (ay_full[CRD_W:RADIUS_W] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_far_ff <= far_in;
         s1_ax_ff  <= ax_full[RADIUS_W-1:0];
         s1_ay_ff  <= ay_full[RADIUS_W-1:0];
         s1_x_ff   <= mask_coord(req.pixel_x);
         s1_y_ff   <= mask_coord(req.pixel_y);
      end
   end

   // Stage 2: squares
   logic               s2_valid_ff, s2_far_ff;
   logic [D2_W-1:0]    s2_sqx_ff, s2_sqy_ff;
   logic [FIELD_W-1:0] s2_x_ff, s2_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_far_ff <= s1_far_ff;
         s2_sqx_ff <= s1_ax_ff * s1_ax_ff;
         s2_sqy_ff <= s1_ay_ff * s1_ay_ff;
         s2_x_ff   <= s1_x_ff;
         s2_y_ff   <= s1_y_ff;
      end
   end

   // Stage 3: squared distance and the radius test
   logic            s3_valid_ff;
   logic [RAD_W-1:0] s3_rad_ff;
   side_type        s3_side_ff;
   logic [D2_W:0]   d2;
   logic            hit_in;

   always_comb begin
      d2     = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
      hit_in = !s2_far_ff && (d2 <= {1'b0, r2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_rad_ff          <= {d2[D2_W-1:0], 16'b0};
         s3_side_ff.x       <= s2_x_ff;
         s3_side_ff.y       <= s2_y_ff;
         s3_side_ff.hit     <= hit_in;
         s3_side_ff.nonzero <= (radius_ff != '0);
      end
   end

   // Distance in Q.8
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   logic [SIDE_W-1:0] sq_side;

   rgcf_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_rad_ff),
      .in_side   (s3_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Position = distance / radius
   logic              dv_valid;
   logic [POS_W-1:0]  dv_quot;
   logic [SIDE_W-1:0] dv_side_vec;
   side_type          dv_side;

   rgcf_div #(.SIDE_W(SIDE_W), .POSITION_FRAC_BITS(P)) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .divisor   ({radius_ff, 8'b0}),
      .in_valid  (sq_valid),
      .in_dist   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side_vec)
   );

   assign dv_side = side_type'(dv_side_vec);

   // Product stage: (end - start) * position per channel
   logic                     pr_valid_ff;
   side_type                 pr_side_ff;
   logic signed [PROD_W-1:0] pr_prod_ff [NUM_CHAN];
   logic [POS_W-1:0]         pos;
   logic signed [PROD_W-1:0] prod_in [NUM_CHAN];
   logic signed [CHAN_W:0]   cdiff [NUM_CHAN];

   always_comb begin
      pos = '0;
      if (dv_side.hit && dv_side.nonzero) begin
         pos = (dv_quot > POS_W'(1) << P) ? POS_W'(1) << P : dv_quot;
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
         cdiff[c]   = signed'({1'b0, end_color_ff[CHAN_W*c +: CHAN_W]})
                    - signed'({1'b0, start_color_ff[CHAN_W*c +: CHAN_W]});
         prod_in[c] = PROD_W'(cdiff[c] * signed'({1'b0, pos}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (advance) begin
         pr_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pr_side_ff <= dv_side;
         for (int c = 0; c < NUM_CHAN; c++) begin
            pr_prod_ff[c] <= prod_in[c];
         end
      end
   end

   // Output stage: add the start colour and drop the fraction
   logic [FIELD_W-1:0]       rsp_x_ff, rsp_y_ff;
   logic                     rsp_inside_ff;
   logic [CHAN_W-1:0]        rsp_chan_ff [NUM_CHAN];
   logic signed [PROD_W-1:0] acc [NUM_CHAN];
   logic [CHAN_W-1:0]        chan_in [NUM_CHAN];

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         acc[c]     = signed'(PROD_W'({start_color_ff[CHAN_W*c +: CHAN_W], P'(0)}))
                    + pr_prod_ff[c];
         chan_in[c] = pr_side_ff.hit ? acc[c][P +: CHAN_W] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_x_ff      <= pr_side_ff.x;
         rsp_y_ff      <= pr_side_ff.y;
         rsp_inside_ff <= pr_side_ff.hit;
         for (int c = 0; c < NUM_CHAN; c++) begin
            rsp_chan_ff[c] <= chan_in[c];
         end
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_x      = signed'(rsp_x_ff);
   assign rsp.out_y      = signed'(rsp_y_ff);
   assign rsp.inside_res = rsp_inside_ff;
   assign rsp.red        = rsp_chan_ff[0];
   assign rsp.green      = rsp_chan_ff[1];
   assign rsp.blue       = rsp_chan_ff[2];
   assign rsp.alpha      = rsp_chan_ff[3];

   // Outside pixels carry no colour
   a_outside_black: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.inside_res |->
         rsp.red == '0 && rsp.green == '0 && rsp.blue == '0 && rsp.alpha == '0)
      else $error("outside pixel has colour");

   // Zero radius gives the start colour for the centre pixel
   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.inside_res && radius_ff == '0 |->
         {rsp.alpha, rsp.blue, rsp.green, rsp.red} == start_color_ff)
      else $error("zero radius colour mismatch");

   // Position of an inside pixel never passes the rim
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      dv_valid && dv_side.hit && dv_side.nonzero |-> dv_quot <= (POS_W'(1) << P))
      else $error("position beyond rim");

   // A stalled pipeline takes no new request
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(s3_rad_ff) && $stable(pr_valid_ff))
      else $error("pipeline moved during stall");

endmodule

@@ dv/tb_radial_gradient_circle_fill.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radial_gradient_circle_fill
// Drives pixel requests and CSR writes into the radial gradient fill with
// random gaps and stalls, and checks every response in order against a
// fixed-point shade predictor or, for directed rows, a typed-in response.
// ----------------------------------------------------------------------------
module tb_radial_gradient_circle_fill;
   import rgcf_pkg::*;

   localparam int PF      = POS_FRAC_BITS_DEF;
   localparam int LATENCY = 26 + PF;

   typedef struct packed {
      logic signed [FIELD_W-1:0] x;
      logic signed [FIELD_W-1:0] y;
      logic                      hit;
      logic [CHAN_W-1:0]         r;
      logic [CHAN_W-1:0]         g;
      logic [CHAN_W-1:0]         b;
      logic [CHAN_W-1:0]         a;
   } shade_type;

   // Directed row: pixel, and a typed-in response where chk_fixed is set
   typedef struct {
      logic signed [FIELD_W-1:0] x;
      logic signed [FIELD_W-1:0] y;
      bit                        chk_fixed;
      shade_type                 fixed;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   rgcf_req_if req ();
   rgcf_rsp_if rsp ();
   rgcf_csr_if csr ();

   radial_gradient_circle_fill uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));

   // Predictor copy of the registers
   logic signed [FIELD_W-1:0]  cen_x, cen_y;
   logic [RADIUS_W-1:0]        rad;
   logic [COLOR_W-1:0]         col_s, col_e;

   shade_type shade_q[$];
   int     errors = 0;
   bit     stall_on = 1;

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic shade_type shade(logic signed [FIELD_W-1:0] px,
                                       logic signed [FIELD_W-1:0] py);
      shade_type o;
      longint dx, dy, acc;
      longint unsigned d2, rr, pos, s, e;
      dx = longint'(px) - longint'(cen_x);
      dy = longint'(py) - longint'(cen_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      d2 = dx * dx + dy * dy;
      rr = 64'(rad);
      o = '0;
      o.x = px;
      o.y = py;
      o.hit = (d2 <= rr * rr);
      pos = 0;
      if (o.hit && rr != 0) begin
         pos = (root64(d2 << 16) << PF) / (rr << 8);
         if (pos > (64'd1 << PF)) pos = 64'd1 << PF;
      end
      if (o.hit) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            s = 64'((col_s >> (8 * c)) & 32'hFF);
            e = 64'((col_e >> (8 * c)) & 32'hFF);
            acc = longint'(s << PF) + (longint'(e) - longint'(s)) * longint'(pos);
            if (acc < 0) acc = 0;
            case (c)
               0: o.r = 8'(acc >> PF);
               1: o.g = 8'(acc >> PF);
               2: o.b = 8'(acc >> PF);
               default: o.a = 8'(acc >> PF);
            endcase
         end
      end
      return o;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Response side: random stalls, in-order compare
   int stall_cnt = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            shade_type got, want;
            got = '{rsp.out_x, rsp.out_y, rsp.inside_res, rsp.red, rsp.green,
                    rsp.blue, rsp.alpha};
            if (shade_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response %h", got);
            end else begin
               want = shade_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %h got %h", want, got);
               end
            end
         end
         if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            rsp.ready <= 1'b0;
         end else if (stall_on && $urandom_range(0, 3) == 0) begin
            stall_cnt <= gap_len();
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      case (idx)
         CSR_CENTER_X:    cen_x = val[FIELD_W-1:0];
         CSR_CENTER_Y:    cen_y = val[FIELD_W-1:0];
         CSR_RADIUS:      rad   = val[RADIUS_W-1:0];
         CSR_START_COLOR: col_s = val;
         CSR_END_COLOR:   col_e = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Valid stays high after acceptance so requests can follow back to back
   task automatic send_pixel(logic signed [FIELD_W-1:0] px,
                             logic signed [FIELD_W-1:0] py, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.pixel_x <= px;
      req.pixel_y <= py;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      shade_q.push_back(shade(px, py));
   endtask

   // Send a table row, with its typed-in response where it has one
   task automatic send_row(row_type rw, bit gaps);
      send_pixel(rw.x, rw.y, gaps);
      if (rw.chk_fixed) shade_q[$] = rw.fixed;
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (shade_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic configure(logic [15:0] cx, logic [15:0] cy, logic [11:0] r,
                            logic [31:0] s, logic [31:0] e);
      csr_write(CSR_CENTER_X, {16'hA5A5, cx});
      csr_write(CSR_CENTER_Y, {16'h5A5A, cy});
      csr_write(CSR_RADIUS, {20'hFFFFF, r});
      csr_write(CSR_START_COLOR, s);
      csr_write(CSR_END_COLOR, e);
   endtask

   row_type rows[$];

   initial begin
      row_type rw;
      int cx, cy, rr, kind;
      logic signed [FIELD_W-1:0] px, py;
      req.valid = 0; req.pixel_x = 0; req.pixel_y = 0;
      csr.valid = 0; csr.index = 0; csr.data = 0;
      cen_x = 0; cen_y = 0; rad = 0; col_s = 0; col_e = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset: zero radius at origin, only the centre is inside, black
      rows.push_back('{16'sd0, 16'sd0, 1, '{16'sd0, 16'sd0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0}});
      rows.push_back('{16'sd1, 16'sd0, 1, '{16'sd1, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0}});
      rows.push_back('{-16'sd32768, 16'sd32767, 1,
                       '{-16'sd32768, 16'sd32767, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0}});
      foreach (rows[i]) send_row(rows[i], 0);
      drain();

      // Zero radius with colors: centre gets the start color
      configure(16'h1234, 16'hFEDC, 12'd0, 32'h11223344, 32'hFFEEDDCC);
      rows.delete();
      rows.push_back('{16'sh1234, -16'sh0124, 1,
                       '{16'sh1234, -16'sh0124, 1'b1, 8'h44, 8'h33, 8'h22, 8'h11}});
      rows.push_back('{16'sh1235, -16'sh0124, 1,
                       '{16'sh1235, -16'sh0124, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0}});
      foreach (rows[i]) send_row(rows[i], 1);
      drain();

      // Largest radius at the coordinate extremes, full color swing
      configure(16'h8000, 16'h7FFF, 12'd4095, 32'h00FF00FF, 32'hFF00FF00);
      rows.delete();
      rw.chk_fixed = 0; rw.fixed = '0;
      rw.x = -16'sd32768; rw.y = 16'sd32767; rows.push_back(rw);
      rw.x = 16'(-32768 + 4095); rows.push_back(rw);
      rw.x = 16'(-32768 + 4096); rows.push_back(rw);
      rw.x = 16'(-32768 + 2896); rw.y = 16'(32767 - 2896); rows.push_back(rw);
      rw.x = 16'sd32767; rw.y = -16'sd32768; rows.push_back(rw);
      rw.x = 16'(-32768 + 2047); rw.y = 16'sd32767; rows.push_back(rw);
      foreach (rows[i]) send_row(rows[i], 0);
      drain();

      // Small radius, rim and one past
      configure(16'd0, 16'd0, 12'd1, 32'hFFFFFFFF, 32'h00000000);
      rows.delete();
      rw.x = 0; rw.y = 1; rows.push_back(rw);
      rw.x = -1; rw.y = 0; rows.push_back(rw);
      rw.x = 1; rw.y = 1; rows.push_back(rw);
      rw.x = 0; rw.y = 0; rows.push_back(rw);
      foreach (rows[i]) send_row(rows[i], 1);
      drain();

      // Unused register index is ignored
      csr_write(3'd7, 32'hDEADBEEF);
      csr_write(3'd5, 32'h0);

      // Random phases: a setting, then a burst of pixels mostly near the circle
      for (int ph = 0; ph < 17; ph++) begin
         stall_on = (ph % 4 != 3);
         rr = (ph % 5 == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64);
         configure(16'($urandom), 16'($urandom), 12'(rr), $urandom, $urandom);
         for (int n = 0; n < 50; n++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
               px = 16'($urandom); py = 16'($urandom);
            end else begin
               cx = $signed(cen_x) + $signed($urandom_range(0, 2 * rr + 4)) - rr - 2;
               cy = $signed(cen_y) + $signed($urandom_range(0, 2 * rr + 4)) - rr - 2;
               px = 16'(cx); py = 16'(cy);
            end
            send_pixel(px, py, ph % 4 != 2);
            // Hold off until every response is back
            if (ph == 1 && n == 25) begin
               req.valid <= 1'b0;
               while (shade_q.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (errors == 0 && shade_q.size() == 0) begin
         $display("tb_radial_gradient_circle_fill OK");
      end else begin
         $display("tb_radial_gradient_circle_fill NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_radial_gradient_circle_fill NOT OK");
      $finish;
   end
endmodule
